// ===== design/ecr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_pkg
// shared constants, types and helpers of the elastic collision response unit
// ----------------------------------------------------------------------------
package ecr_pkg;

  localparam int FRAC = 16;
  localparam int QW   = FRAC + 2;
  localparam int NW   = FRAC + 33;
  localparam int DW   = 33;
  localparam int SQ   = 32;

  localparam logic [31:0] TICK_RST = 32'(1) << FRAC;
  localparam logic [31:0] MIND_RST = 32'd1;

  typedef enum logic [0:0] {
    CFG_TICK_SCALE   = 1'b0,
    CFG_MIN_DISTANCE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0][31:0] rel;
    logic [2:0][31:0] vel_a;
    logic [2:0][31:0] vel_b;
    logic [31:0]      mass_a;
    logic [31:0]      mass_b;
    logic [63:0]      sq;
    logic             too_close;
  } item_t;

  typedef struct packed {
    logic             too_close;
    logic [2:0]       rneg;
    logic [2:0][31:0] rmag;
    logic [2:0][31:0] v;
    logic [2:0][31:0] w;
    logic [31:0]      mass_a;
    logic [31:0]      mass_b;
  } pay_t;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

endpackage

// ===== design/ecr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_fifo
// four-entry queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
module ecr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ecr_pkg::item_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ecr_pkg::item_t data_o
);

  ecr_pkg::item_t mem_q [4];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q[2];
  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 2'd1 : wr_q;
    rd_d  = do_pop ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {2'd0, do_push} - {2'd0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/ecr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_front
// takes requests, squares the offset and flags pairs that are too close
// ----------------------------------------------------------------------------
module ecr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [351:0]   data_i,
  input  logic [31:0]    min_distance_i,
  input  logic           full_i,
  output logic           push_o,
  output ecr_pkg::item_t item_o
);

  ecr_pkg::item_t   fa_d, fa_q, fb_q;
  logic             fa_vld_q, fb_vld_q, f_en;
  logic [63:0]      md_sq_q, md_sq_d, sum;
  logic [2:0][63:0] sq_d, fb_sq_q;

  assign f_en    = !fb_vld_q || !full_i;
  assign ready_o = f_en;
  assign push_o  = fb_vld_q && !full_i;
  assign md_sq_d = min_distance_i * min_distance_i;

  always_comb begin
    fa_d = '0;
    for (int i = 0; i < 3; i++) begin
      fa_d.rel[i]   = data_i[32*i +: 32];
      fa_d.vel_a[i] = data_i[96 + 32*i +: 32];
      fa_d.vel_b[i] = data_i[192 + 32*i +: 32];
      sq_d[i]       = ecr_pkg::mag32(fa_q.rel[i]) * ecr_pkg::mag32(fa_q.rel[i]);
    end
    fa_d.mass_a = data_i[319:288];
    fa_d.mass_b = data_i[351:320];
  end

  always_comb begin
    sum              = fb_sq_q[0] + fb_sq_q[1] + fb_sq_q[2];
    item_o           = fb_q;
    item_o.sq        = sum;
    item_o.too_close = (sum == 64'd0) || (sum < md_sq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_vld_q <= 1'b0;
      fb_vld_q <= 1'b0;
      md_sq_q  <= 64'd1;
    end else begin
      md_sq_q <= md_sq_d;
      if (f_en) begin
        fa_vld_q <= valid_i;
        fb_vld_q <= fa_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en) begin
      fa_q    <= fa_d;
      fb_q    <= fa_q;
      fb_sq_q <= sq_d;
    end
  end

endmodule

// ===== design/ecr_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module ecr_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] s_i,
  output logic [31:0] res_o
);

  logic [63:0] s_q [ecr_pkg::SQ];
  logic [63:0] r_q [ecr_pkg::SQ];

  for (genvar i = 0; i < ecr_pkg::SQ; i++) begin : g_st
    logic [63:0] bit_w, in_s, in_r, s_d, r_d;
    logic [64:0] t;
    always_comb begin
      bit_w = 64'd1 << (62 - 2 * i);
      in_s  = (i == 0) ? s_i : s_q[(i == 0) ? 0 : i - 1];
      in_r  = (i == 0) ? 64'd0 : r_q[(i == 0) ? 0 : i - 1];
      t     = {1'b0, in_r} + {1'b0, bit_w};
      if ({1'b0, in_s} >= t) begin
        s_d = in_s - t[63:0];
        r_d = (in_r >> 1) + bit_w;
      end else begin
        s_d = in_s;
        r_d = in_r >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i] <= s_d;
        r_q[i] <= r_d;
      end
    end
  end

  assign res_o = r_q[ecr_pkg::SQ-1][31:0];

endmodule

// ===== design/ecr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ecr_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ecr_pkg::NW-1:0]   num_i,
  input  logic [ecr_pkg::DW-1:0]   den_i,
  output logic [ecr_pkg::QW-1:0]   quo_o
);

  localparam int RW = ecr_pkg::DW + ecr_pkg::QW;

  logic [RW-1:0]          rem_q [ecr_pkg::QW];
  logic [ecr_pkg::DW-1:0] den_q [ecr_pkg::QW];
  logic [ecr_pkg::QW-1:0] quo_q [ecr_pkg::QW];

  for (genvar i = 0; i < ecr_pkg::QW; i++) begin : g_st
    localparam int K = ecr_pkg::QW - 1 - i;
    logic [RW-1:0]          in_rem, sh, rem_d;
    logic [ecr_pkg::DW-1:0] in_den;
    logic [ecr_pkg::QW-1:0] in_quo, quo_d;
    always_comb begin
      in_rem = (i == 0) ? RW'(num_i) : rem_q[(i == 0) ? 0 : i - 1];
      in_den = (i == 0) ? den_i : den_q[(i == 0) ? 0 : i - 1];
      in_quo = (i == 0) ? '0 : quo_q[(i == 0) ? 0 : i - 1];
      sh     = RW'(in_den) << K;
      rem_d  = in_rem;
      quo_d  = in_quo;
      if (in_rem >= sh) begin
        rem_d    = in_rem - sh;
        quo_d[K] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        den_q[i] <= in_den;
        quo_q[i] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[ecr_pkg::QW-1];

endmodule

// ===== design/ecr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_back
// normalises the offset, splits the velocities and applies the elastic exchange
// ----------------------------------------------------------------------------
module ecr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fifo_valid_i,
  input  ecr_pkg::item_t item_i,
  output logic           pop_o,
  input  logic [31:0]    tick_scale_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [191:0]   m_data_o,
  output logic           m_user_o
);

  localparam int SQ = ecr_pkg::SQ;
  localparam int QW = ecr_pkg::QW;
  localparam int NW = ecr_pkg::NW;
  localparam int FRAC = ecr_pkg::FRAC;

  function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
    if (neg) begin
      return (m > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  function automatic logic [31:0] sat41(input logic [40:0] x);
    if (x[40] && (x[39:31] != 9'h1FF)) begin
      return 32'h8000_0000;
    end
    if (!x[40] && (x[39:31] != 9'h000)) begin
      return 32'h7FFF_FFFF;
    end
    return x[31:0];
  endfunction

  logic en;
  assign en    = !m_valid_o || m_ready_i;
  assign pop_o = en && fifo_valid_i;

  // control
  logic          p1_vld_q, p2_vld_q, out_vld_q;
  logic [SQ-1:0] dly_vld_q;
  logic [QW-1:0] dly2_vld_q;
  logic [5:0]    s_vld_q;

  // payload
  ecr_pkg::item_t    p1_q, p2_q;
  logic [2:0][63:0]  prod_a_q, prod_b_q;
  ecr_pkg::pay_t     pay_d;
  ecr_pkg::pay_t     dly_q  [SQ];
  ecr_pkg::pay_t     dly2_q [QW];
  ecr_pkg::pay_t     s1_pay_q, s2_pay_q, s3_pay_q, s4_pay_q, s5_pay_q, s6_pay_q;
  logic [31:0]       len;
  logic [32:0]       msum;
  logic [2:0][QW-1:0] nq;
  logic [QW-1:0]     raq, rbq;
  logic [2:0][QW-1:0] s1_n_q, s2_n_q, s3_n_q;
  logic [QW-1:0]     s1_ra_q, s2_ra_q, s3_ra_q, s4_ra_q, s5_ra_q;
  logic [QW-1:0]     s1_rb_q, s2_rb_q, s3_rb_q, s4_rb_q, s5_rb_q;
  logic [2:0][32:0]  tv_d, tw_d, s2_tv_q, s2_tw_q;
  logic [34:0]       dv_d, dw_d, s3_dv_q, s3_dw_q;
  logic [2:0][35:0]  vn_d, wn_d, s4_vn_q, s4_wn_q;
  logic [2:0][36:0]  df_d, s5_df_q;
  logic [2:0][39:0]  pa_d, pb_d, s6_pa_q, s6_pb_q;
  logic [191:0]      out_d, out_q;
  logic              user_q;

  always_comb begin
    pay_d.too_close = p2_q.too_close;
    pay_d.mass_a    = p2_q.mass_a;
    pay_d.mass_b    = p2_q.mass_b;
    for (int i = 0; i < 3; i++) begin
      pay_d.rneg[i] = p2_q.rel[i][31];
      pay_d.rmag[i] = ecr_pkg::mag32(p2_q.rel[i]);
      pay_d.v[i]    = sat_mag(prod_a_q[i] >> FRAC, p2_q.vel_a[i][31]);
      pay_d.w[i]    = sat_mag(prod_b_q[i] >> FRAC, p2_q.vel_b[i][31]);
    end
  end

  ecr_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .s_i   (p2_q.sq),
    .res_o (len)
  );

  assign msum = {1'b0, dly_q[SQ-1].mass_a} + {1'b0, dly_q[SQ-1].mass_b};

  for (genvar i = 0; i < 3; i++) begin : g_ndiv
    ecr_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (NW'(dly_q[SQ-1].rmag[i]) << FRAC),
      .den_i ({1'b0, len}),
      .quo_o (nq[i])
    );
  end

  ecr_div u_div_ra (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (NW'({dly_q[SQ-1].mass_a, 1'b0}) << FRAC),
    .den_i (msum),
    .quo_o (raq)
  );

  ecr_div u_div_rb (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (NW'({dly_q[SQ-1].mass_b, 1'b0}) << FRAC),
    .den_i (msum),
    .quo_o (rbq)
  );

  logic massless;
  assign massless = (dly2_q[QW-1].mass_a == 32'd0) && (dly2_q[QW-1].mass_b == 32'd0);

  always_comb begin
    logic [QW+31:0] pv, pw;
    logic [QW+34:0] pn, pm;
    logic [34:0]    dvm, dwm;
    logic [QW+36:0] qa, qb;
    logic [36:0]    dm;
    logic [40:0]    sa, sb;
    dvm = s3_dv_q[34] ? (35'd0 - s3_dv_q) : s3_dv_q;
    dwm = s3_dw_q[34] ? (35'd0 - s3_dw_q) : s3_dw_q;
    dv_d = '0;
    dw_d = '0;
    for (int i = 0; i < 3; i++) begin
      pv = s1_n_q[i] * ecr_pkg::mag32(s1_pay_q.v[i]);
      pw = s1_n_q[i] * ecr_pkg::mag32(s1_pay_q.w[i]);
      tv_d[i] = (s1_pay_q.rneg[i] ^ s1_pay_q.v[i][31]) ? (33'd0 - 33'(pv >> FRAC))
                                                       : 33'(pv >> FRAC);
      tw_d[i] = (s1_pay_q.rneg[i] ^ s1_pay_q.w[i][31]) ? (33'd0 - 33'(pw >> FRAC))
                                                       : 33'(pw >> FRAC);
      dv_d = dv_d + {{2{s2_tv_q[i][32]}}, s2_tv_q[i]};
      dw_d = dw_d + {{2{s2_tw_q[i][32]}}, s2_tw_q[i]};
      pn = s3_n_q[i] * dvm;
      pm = s3_n_q[i] * dwm;
      vn_d[i] = (s3_pay_q.rneg[i] ^ s3_dv_q[34]) ? (36'd0 - 36'(pn >> FRAC))
                                                 : 36'(pn >> FRAC);
      wn_d[i] = (s3_pay_q.rneg[i] ^ s3_dw_q[34]) ? (36'd0 - 36'(pm >> FRAC))
                                                 : 36'(pm >> FRAC);
      df_d[i] = {s4_wn_q[i][35], s4_wn_q[i]} - {s4_vn_q[i][35], s4_vn_q[i]};
      dm = s5_df_q[i][36] ? (37'd0 - s5_df_q[i]) : s5_df_q[i];
      qa = dm * s5_rb_q;
      qb = dm * s5_ra_q;
      pa_d[i] = s5_df_q[i][36] ? (40'd0 - 40'(qa >> FRAC)) : 40'(qa >> FRAC);
      pb_d[i] = s5_df_q[i][36] ? 40'(qb >> FRAC) : (40'd0 - 40'(qb >> FRAC));
      sa = {{9{s6_pay_q.v[i][31]}}, s6_pay_q.v[i]} + {s6_pa_q[i][39], s6_pa_q[i]};
      sb = {{9{s6_pay_q.w[i][31]}}, s6_pay_q.w[i]} + {s6_pb_q[i][39], s6_pb_q[i]};
      out_d[32*i +: 32]      = s6_pay_q.too_close ? 32'd0 : sat41(sa);
      out_d[96 + 32*i +: 32] = s6_pay_q.too_close ? 32'd0 : sat41(sb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      dly_vld_q  <= '0;
      dly2_vld_q <= '0;
      s_vld_q    <= '0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      p1_vld_q   <= fifo_valid_i;
      p2_vld_q   <= p1_vld_q;
      dly_vld_q  <= {dly_vld_q[SQ-2:0], p2_vld_q};
      dly2_vld_q <= {dly2_vld_q[QW-2:0], dly_vld_q[SQ-1]};
      s_vld_q    <= {s_vld_q[4:0], dly2_vld_q[QW-1]};
      out_vld_q  <= s_vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= item_i;
      p2_q <= p1_q;
      for (int i = 0; i < 3; i++) begin
        prod_a_q[i] <= ecr_pkg::mag32(p1_q.vel_a[i]) * tick_scale_i;
        prod_b_q[i] <= ecr_pkg::mag32(p1_q.vel_b[i]) * tick_scale_i;
      end
      dly_q[0] <= pay_d;
      for (int k = 1; k < SQ; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
      dly2_q[0] <= dly_q[SQ-1];
      for (int k = 1; k < QW; k++) begin
        dly2_q[k] <= dly2_q[k-1];
      end
      s1_pay_q <= dly2_q[QW-1];
      s1_n_q   <= nq;
      s1_ra_q  <= massless ? (QW'(1) << FRAC) : raq;
      s1_rb_q  <= massless ? (QW'(1) << FRAC) : rbq;
      s2_pay_q <= s1_pay_q;
      s2_n_q   <= s1_n_q;
      s2_ra_q  <= s1_ra_q;
      s2_rb_q  <= s1_rb_q;
      s2_tv_q  <= tv_d;
      s2_tw_q  <= tw_d;
      s3_pay_q <= s2_pay_q;
      s3_n_q   <= s2_n_q;
      s3_ra_q  <= s2_ra_q;
      s3_rb_q  <= s2_rb_q;
      s3_dv_q  <= dv_d;
      s3_dw_q  <= dw_d;
      s4_pay_q <= s3_pay_q;
      s4_ra_q  <= s3_ra_q;
      s4_rb_q  <= s3_rb_q;
      s4_vn_q  <= vn_d;
      s4_wn_q  <= wn_d;
      s5_pay_q <= s4_pay_q;
      s5_ra_q  <= s4_ra_q;
      s5_rb_q  <= s4_rb_q;
      s5_df_q  <= df_d;
      s6_pay_q <= s5_pay_q;
      s6_pa_q  <= pa_d;
      s6_pb_q  <= pb_d;
      out_q    <= out_d;
      user_q   <= s6_pay_q.too_close;
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_q;
  assign m_user_o  = user_q;

endmodule

// ===== design/elastic_collision_response_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_collision_response_unit
// two-body elastic collision response in Q16.16 fixed point
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one colliding pair per request: offset of A from B,
//   both velocities and both masses. m_axis returns both displacements for
//   the tick, with tuser set when the offset is zero or shorter than min_distance
//   (displacements are then zero).
//   cfg_we_i / cfg_idx_i / cfg_data_i write tick_scale (0) and
//   min_distance (1); write them only while the block is idle.
//   one pair is accepted every cycle while the queue is not full. from s_axis
//   acceptance to m_axis valid a pair passes the second front stage, the
//   queue, two operand stages, the 32-stage square root, the 18-stage
//   dividers, six exchange stages and the output register.
//   a stalled m_axis freezes the back pipeline; the front keeps taking
//   pairs until the queue fills, then drops s_axis_tready.
//   reset empties every stage and the queue and sets tick_scale to 1.0
//   and min_distance to 1.
// ----------------------------------------------------------------------------
module elastic_collision_response_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rel_x, rel_y, rel_z, vel_a_x..z, vel_b_x..z, mass_a, mass_b
  input  logic [351:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // disp_a_x, disp_a_y, disp_a_z, disp_b_x, disp_b_y, disp_b_z
  output logic [191:0] m_axis_tdata,
  // too_close
  output logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  logic [31:0]    tick_scale_q, min_dist_q;
  logic           fifo_full, fifo_push, fifo_valid, fifo_pop;
  ecr_pkg::item_t front_item, back_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_scale_q <= ecr_pkg::TICK_RST;
      min_dist_q   <= ecr_pkg::MIND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecr_pkg::CFG_TICK_SCALE:   tick_scale_q <= cfg_data_i;
        ecr_pkg::CFG_MIN_DISTANCE: min_dist_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ecr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .data_i         (s_axis_tdata),
    .min_distance_i (min_dist_q),
    .full_i         (fifo_full),
    .push_o         (fifo_push),
    .item_o         (front_item)
  );

  ecr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (back_item)
  );

  ecr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .item_i       (back_item),
    .pop_o        (fifo_pop),
    .tick_scale_i (tick_scale_q),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_user_o     (m_axis_tuser)
  );

endmodule

// ===== tb/elastic_collision_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_collision_response_checker
// watches both streams, predicts the collision response of every accepted
// request and compares each returned result field by field, in order
// ----------------------------------------------------------------------------
module elastic_collision_response_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [351:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [191:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_we_i,
  input  ecr_pkg::cfg_idx_e cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output int           errors_o,
  output int           pending_o,
  output int           results_o,
  output int           close_o
);

  localparam int F = ecr_pkg::FRAC;

  typedef struct packed {
    logic         too_close;
    logic [191:0] disp;
  } response_t;

  response_t   response_q[$];
  logic [31:0] tick_scale;
  logic [31:0] min_distance;

  assign pending_o = response_q.size();

  function automatic logic [63:0] abs64(input longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint mul_q(input longint a, input longint b);
    logic [63:0] p;
    p = (abs64(a) * abs64(b)) >> F;
    p[63] = 1'b0;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] s);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic response_t collide(input logic [351:0] d);
    response_t   r;
    longint      rel[3], n[3], v[3], w[3], vn[3], wn[3];
    longint      dv, dw, vnp, wnp;
    logic [63:0] s, len, sum, ra, rb, ma, mb;
    r = '0;
    s = 0;
    dv = 0;
    dw = 0;
    for (int i = 0; i < 3; i++) begin
      rel[i] = longint'($signed(d[32*i +: 32]));
      s += abs64(rel[i]) * abs64(rel[i]);
    end
    if (s == 0 || s < 64'(min_distance) * 64'(min_distance)) begin
      r.too_close = 1'b1;
      return r;
    end
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      n[i] = longint'((abs64(rel[i]) << F) / len);
      if (rel[i] < 0) n[i] = -n[i];
      v[i] = clip32(mul_q(longint'($signed(d[96+32*i +: 32])), longint'(tick_scale)));
      w[i] = clip32(mul_q(longint'($signed(d[192+32*i +: 32])), longint'(tick_scale)));
      dv += mul_q(n[i], v[i]);
      dw += mul_q(n[i], w[i]);
    end
    ma = 64'(d[288 +: 32]);
    mb = 64'(d[320 +: 32]);
    sum = ma + mb;
    if (sum == 0) begin
      ra = 64'd1 << F;
      rb = ra;
    end else begin
      ra = ((2 * ma) << F) / sum;
      rb = ((2 * mb) << F) / sum;
    end
    for (int i = 0; i < 3; i++) begin
      vn[i] = mul_q(n[i], dv);
      wn[i] = mul_q(n[i], dw);
      vnp = vn[i] + mul_q(wn[i] - vn[i], longint'(rb));
      wnp = wn[i] + mul_q(vn[i] - wn[i], longint'(ra));
      r.disp[32*i +: 32]     = 32'(clip32(vnp + (v[i] - vn[i])));
      r.disp[96+32*i +: 32]  = 32'(clip32(wnp + (w[i] - wn[i])));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    response_t want;
    string names[6];
    names = '{"disp_a_x", "disp_a_y", "disp_a_z", "disp_b_x", "disp_b_y", "disp_b_z"};
    if (!rst_ni) begin
      tick_scale   <= ecr_pkg::TICK_RST;
      min_distance <= ecr_pkg::MIND_RST;
      response_q.delete();
      errors_o  = 0;
      results_o <= 0;
      close_o   <= 0;
    end else begin
      // requests see the registers as they were before this edge
      if (s_axis_tvalid && s_axis_tready) response_q.push_back(collide(s_axis_tdata));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ecr_pkg::CFG_TICK_SCALE:   tick_scale   <= cfg_data_i;
          ecr_pkg::CFG_MIN_DISTANCE: min_distance <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_o <= results_o + 1;
        if (m_axis_tuser) close_o <= close_o + 1;
        if (response_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_axis_tuser), 32'd0);
        end else begin
          want = response_q.pop_front();
          if (m_axis_tuser !== want.too_close)
            report_mismatch("too_close", 32'(m_axis_tuser), 32'(want.too_close));
          for (int i = 0; i < 6; i++)
            if (m_axis_tdata[32*i +: 32] !== want.disp[32*i +: 32])
              report_mismatch(names[i], m_axis_tdata[32*i +: 32], want.disp[32*i +: 32]);
        end
      end
    end
  end

endmodule

// ===== tb/elastic_collision_response_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_collision_response_unit_test
// drives directed and random collision pairs through the unit under several
// register settings and random idling on both streams; the checker predicts
// and compares every result
// ----------------------------------------------------------------------------
module elastic_collision_response_unit_test;

  localparam int LATENCY = 80;
  localparam int LIMIT   = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [351:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  ecr_pkg::cfg_idx_e cfg_idx_i = ecr_pkg::CFG_TICK_SCALE;
  logic [31:0]  cfg_data_i = '0;

  int errors, pending, results, close_count, cycles;
  int send_idle, recv_idle;
  int hold_off = 0;
  logic hold_req = 1'b0;
  int sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  elastic_collision_response_unit u_dut (.*);

  elastic_collision_response_checker u_check (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .results_o(results), .close_o(close_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_off <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly moderate values so the exchange is exercised without saturation
  function automatic logic [351:0] random_pair();
    logic [351:0] d;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 11; i++) begin
      if (mode == 0) d[32*i +: 32] = edge_word();
      else if (mode < 3) d[32*i +: 32] = $urandom;
      else d[32*i +: 32] = 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
    end
    if (mode >= 3) begin
      d[288 +: 32] = $urandom_range(32'h0010_0000, 1);
      d[320 +: 32] = $urandom_range(32'h0010_0000, 1);
    end
    if (d[288 +: 32] == 0) d[288 +: 32] = 1;
    if (d[320 +: 32] == 0) d[320 +: 32] = 1;
    return d;
  endfunction

  function automatic logic [351:0] pack_pair(input logic [31:0] rx, ry, rz, va, vb,
                                             ma, mb);
    return {mb, ma, vb, vb, vb, va, va, va, rz, ry, rx};
  endfunction

  task automatic send(input logic [351:0] d);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || hold_off != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input ecr_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) send(random_pair());
  endtask

  initial begin
    send_idle = 23;
    recv_idle = 55;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero offset, too close, equal and extreme masses
    send(pack_pair(0, 0, 0, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 32'h0001_0000));
    send(pack_pair(1, 0, 0, 32'h0001_0000, 0, 1, 1));
    send(pack_pair(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000));
    send(pack_pair(0, 32'hffff_0000, 0, 32'h0002_0000, 32'hfffe_0000, 32'h0003_0000,
                   32'h0001_0000));
    send(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send(pack_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h8000_0000, 1, 32'hffff_ffff));
    send(pack_pair(32'hffff_ffff, 1, 32'hffff_ffff, 32'hffff_ffff, 1, 32'hffff_ffff, 1));
    send(pack_pair(3, 4, 0, 32'h0010_0000, 32'hfff0_0000, 32'h0002_0000, 32'h0002_0000));
    for (int i = 0; i < 12; i++) begin
      send({edge_word() | 32'd1, edge_word() | 32'd1, edge_word(), edge_word(),
            edge_word(), edge_word(), edge_word(), edge_word(), edge_word(),
            edge_word(), edge_word()});
    end
    drain();

    // tick at zero, min_distance large so many pairs are too close
    write_reg(ecr_pkg::CFG_TICK_SCALE, 32'd0);
    write_reg(ecr_pkg::CFG_MIN_DISTANCE, 32'h0010_0000);
    random_phase(60);
    // receiver holds off long enough to fill the pipeline and stall the input
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    random_phase(100);
    drain();

    send_idle = 55;
    recv_idle = 23;
    write_reg(ecr_pkg::CFG_TICK_SCALE, 32'hffff_ffff);
    write_reg(ecr_pkg::CFG_MIN_DISTANCE, 32'hffff_ffff);
    random_phase(60);
    drain();
    write_reg(ecr_pkg::CFG_MIN_DISTANCE, 32'd0);
    write_reg(ecr_pkg::CFG_TICK_SCALE, 32'h0000_8000);
    random_phase(100);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_reg(ecr_pkg::CFG_TICK_SCALE, 32'h0001_0000);
    write_reg(ecr_pkg::CFG_MIN_DISTANCE, 32'h0000_0100);
    random_phase(120);
    drain();

    $display("%0d pairs sent, %0d results checked, %0d flagged too close",
             sent, results, close_count);
    $display("register settings included zero and full-scale tick and distance");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
